### rtl/sst_pkg.sv
// shared constants, types and state codes of the sorted set span tracker
package sst_pkg;

    // field and register widths
    localparam int DATA_W          = 32;
    localparam int CNT_W           = 7;
    localparam int CAP_W           = 7;
    localparam int ADDR_W          = 3;
    localparam int PDATA_W         = 32;
    localparam int MAX_ENTRIES_DEF = 64;

    // register index of capacity in the config address space
    localparam logic REG_CAPACITY = 1'b0;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_REPORT
    } sst_state_t;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              occ;
        logic              take;
    } sst_link_t;

    // strobes broadcast to every cell
    typedef struct packed {
        logic capture;
        logic shift;
    } sst_ctrl_t;

endpackage

### rtl/sorted_set_span_tracker_core.sv
// top level: sorted set span tracker built on a chain of insertion cells
//
//   channel  | signals                                   | role
//   ---------+-------------------------------------------+--------------------------
//   in       | in_valid, in_ready, command, value        | add or query beat
//   out      | out_valid, out_ready, status, count,      | one result beat per input
//            | spans_valid, shortest_span, longest_span  |
//   config   | psel, penable, pwrite, paddr, pwdata,     | capacity register at 0x0
//            | prdata, pready                            |
//
// for each item: on accept each cell latches its insert decision, in the shift state
// an accepted add shifts the chain and updates the minimum gap, and in the report state
// the result register loads while the next beat may be accepted
// back pressure on out holds the block in its report state with in_ready low
// reset empties the set, clears capacity to 0 and sets the minimum gap to all ones
module sorted_set_span_tracker_core
    import sst_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     status,
    output logic        [CNT_W-1:0]  count,
    output logic                     spans_valid,
    output logic        [DATA_W-1:0] shortest_span,
    output logic        [DATA_W-1:0] longest_span,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic        [ADDR_W-1:0] paddr,
    input  logic       [PDATA_W-1:0] pwdata,
    output logic       [PDATA_W-1:0] prdata,
    output logic                     pready
);

    localparam int LIM_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;

    sst_ctrl_t         ctrl;
    logic              load_out;
    sst_link_t         links [MAX_ENTRIES+1];
    logic [DATA_W-1:0] cands [MAX_ENTRIES];

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] gap_reg;
    logic [DATA_W-1:0] v_reg;
    logic              add_ok_reg;
    logic              status_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_spans_reg;
    logic [DATA_W-1:0] out_short_reg;
    logic [DATA_W-1:0] out_long_reg;

    logic              full;
    logic              cfg_write;
    logic [DATA_W-1:0] cand_any;
    logic [DATA_W-1:0] last_value;
    logic [DATA_W-1:0] gap_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ?
                       {{(PDATA_W-CAP_W){1'b0}}, capacity_reg} : '0;

    // full when count reaches the capacity or the chain length
    assign full = (CMP_W'(count_reg) >= CMP_W'(MAX_ENTRIES)) ||
                  (count_reg >= capacity_reg);

    sst_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_ready     (out_ready),
        .out_valid_cur (out_valid_reg),
        .add_ok        (add_ok_reg),
        .ctrl          (ctrl),
        .load_out      (load_out)
    );

    // left end of the chain: no neighbor, never takes
    assign links[0] = '{value: '0, occ: 1'b0, take: 1'b0};

    // cell chain
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        sst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .cmp_value (value),
            .ins_value (v_reg),
            .left      (links[i]),
            .right     (links[i+1]),
            .gap_cand  (cands[i])
        );
    end

    // gather the insert point gap and the largest held value
    always_comb
    begin
        cand_any   = '0;
        last_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            cand_any = cand_any | cands[i];
        end
        for (int i = 0; i < MAX_ENTRIES - 1; i++)
        begin
            if (links[i+1].occ && !links[i+2].occ)
            begin
                last_value = last_value | links[i+1].value;
            end
        end
        // last cell has no right neighbor
        if (links[MAX_ENTRIES].occ)
        begin
            last_value = last_value | links[MAX_ENTRIES].value;
        end
        gap_next = (cand_any < gap_reg) ? cand_any : gap_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            count_reg     <= '0;
            gap_reg       <= {DATA_W{1'b1}};
            add_ok_reg    <= 1'b0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end
            if (ctrl.capture)
            begin
                add_ok_reg <= (command == CMD_ADD) && !full;
                status_reg <= ((command == CMD_ADD) && full) ? STATUS_FULL : STATUS_OK;
            end
            if (ctrl.shift)
            begin
                count_reg <= count_reg + CNT_W'(1);
                gap_reg   <= gap_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            v_reg <= value;
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
            out_spans_reg  <= (count_reg >= CNT_W'(2));
            out_short_reg  <= (count_reg >= CNT_W'(2)) ? gap_reg : '0;
            out_long_reg   <= (count_reg >= CNT_W'(2)) ?
                              (last_value - links[1].value) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign count         = out_count_reg;
    assign spans_valid   = out_spans_reg;
    assign shortest_span = out_short_reg;
    assign longest_span  = out_long_reg;

endmodule

### rtl/sst_cell.sv
// one slot of the sorted chain: holds a value, decides its insert role, shifts right
module sst_cell
    import sst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sst_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] cmp_value,
    input  logic [DATA_W-1:0] ins_value,
    input  sst_link_t         left,
    output sst_link_t         right,
    output logic [DATA_W-1:0] gap_cand
);

    logic [DATA_W-1:0] value_reg;
    logic              occ_reg;
    logic              take_reg;
    logic              take_next;
    logic              point;
    logic [DATA_W-1:0] left_gap;
    logic [DATA_W-1:0] right_gap;

    // slot belongs at or after the insert point: empty or strictly greater
    assign take_next = !occ_reg || ($signed(value_reg) > $signed(cmp_value));

    // first taking slot is where the new value lands
    assign point = take_reg && !left.take;

    // neighbor gaps around the new value, all ones when the neighbor is absent
    always_comb
    begin
        left_gap  = left.occ ? (ins_value - left.value) : {DATA_W{1'b1}};
        right_gap = occ_reg ? (value_reg - ins_value) : {DATA_W{1'b1}};
        if (!point)
        begin
            gap_cand = '0;
        end
        else if (left_gap < right_gap)
        begin
            gap_cand = left_gap;
        end
        else
        begin
            gap_cand = right_gap;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            take_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                take_reg <= take_next;
            end
            if (ctrl.shift && take_reg)
            begin
                occ_reg <= left.take ? left.occ : 1'b1;
            end
        end
    end

    // payload: shift in from the left or load the new value
    always_ff @(posedge clk)
    begin
        if (ctrl.shift && take_reg)
        begin
            value_reg <= left.take ? left.value : ins_value;
        end
    end

    assign right.value = value_reg;
    assign right.occ   = occ_reg;
    assign right.take  = take_reg;

endmodule

### rtl/sst_ctrl.sv
// sequencer: beat acceptance, shift strobe and result register handoff
module sst_ctrl
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    input  logic      out_valid_cur,
    input  logic      add_ok,
    output sst_ctrl_t ctrl,
    output logic      load_out
);

    sst_state_t state_reg;
    sst_state_t state_next;
    logic       slot_free;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and strobes
    always_comb
    begin
        slot_free    = !out_valid_cur || out_ready;
        state_next   = state_reg;
        in_ready     = 1'b0;
        load_out     = 1'b0;
        ctrl.shift   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                ctrl.shift = add_ok;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                load_out = slot_free;
                in_ready = slot_free;
                if (slot_free)
                begin
                    state_next = in_valid ? ST_SHIFT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ctrl.capture = in_valid && in_ready;
    end

endmodule

### dv/testbench.sv
// self-checking testbench for the sorted set span tracker core
module testbench;
    import sst_pkg::*;

    localparam int          SET_DEPTH   = MAX_ENTRIES_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          ITEMS_PER_PHASE = 56;
    localparam logic [ADDR_W-1:0] CAP_ADDR      = ADDR_W'(4 * REG_CAPACITY);
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4 * (REG_CAPACITY + 1));

    // one input beat
    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] val;
    } set_op_t;

    // one result beat
    typedef struct packed {
        logic              status;
        logic [CNT_W-1:0]  count;
        logic              spans_valid;
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
    } span_report_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     command  = CMD_QUERY;
    logic        [DATA_W-1:0] value    = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     status;
    logic        [CNT_W-1:0]  count;
    logic                     spans_valid;
    logic        [DATA_W-1:0] shortest_span;
    logic        [DATA_W-1:0] longest_span;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic        [ADDR_W-1:0] paddr;
    logic       [PDATA_W-1:0] pwdata;
    logic       [PDATA_W-1:0] prdata;
    logic                     pready;

    // predicted contents of the set
    logic [DATA_W-1:0] held_vals [SET_DEPTH];
    int unsigned       held_n;
    logic [DATA_W-1:0] min_gap;
    int unsigned       cap_reg;

    set_op_t           ops_to_send [$];
    span_report_t      expected_reports [$];
    logic [DATA_W-1:0] sent_values [$];
    logic [DATA_W-1:0] cluster_base;

    int  items_queued  = 0;
    int  reports_seen  = 0;
    int  fault_count   = 0;
    int  cycle_count   = 0;
    bit  in_taken      = 1'b0;
    bit  out_taken     = 1'b0;
    int  in_gap        = 0;
    int  out_stall     = 0;
    bit  in_steady     = 1'b0;
    bit  out_steady    = 1'b0;

    sorted_set_span_tracker_core #(
        .MAX_ENTRIES (SET_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .count         (count),
        .spans_valid   (spans_valid),
        .shortest_span (shortest_span),
        .longest_span  (longest_span),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // insert into the predicted set and build the report for this beat
    function automatic span_report_t insert_and_report(logic cmd, logic [DATA_W-1:0] v);
        int unsigned       lim;
        int unsigned       p;
        int unsigned       i;
        logic [DATA_W-1:0] gap;
        span_report_t      r;
        lim      = (cap_reg > SET_DEPTH) ? SET_DEPTH : cap_reg;
        r        = '0;
        r.status = STATUS_OK;
        if (cmd == CMD_ADD)
        begin
            if (held_n >= lim)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                // equal values go after the ones already held
                p = 0;
                while (p < held_n && $signed(held_vals[p]) <= $signed(v))
                    p++;
                for (i = held_n; i > p; i--)
                    held_vals[i] = held_vals[i - 1];
                held_vals[p] = v;
                held_n++;
                // only the two new neighbor gaps can lower the minimum
                if (p > 0)
                begin
                    gap = v - held_vals[p - 1];
                    if (gap < min_gap)
                        min_gap = gap;
                end
                if (p + 1 < held_n)
                begin
                    gap = held_vals[p + 1] - v;
                    if (gap < min_gap)
                        min_gap = gap;
                end
            end
        end
        r.count = CNT_W'(held_n);
        if (held_n >= 2)
        begin
            r.spans_valid = 1'b1;
            r.shortest    = min_gap;
            r.longest     = held_vals[held_n - 1] - held_vals[0];
        end
        return r;
    endfunction

    function automatic void compare_field(string what, logic [DATA_W-1:0] exp_v,
                                          logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
        end
    endfunction

    // mix of extremes, tight clusters, repeats and uniform values
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        if ($urandom_range(0, 15) == 0)
            cluster_base = $urandom;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: v = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
            2, 3: v = cluster_base + $urandom_range(0, 40);
            4: v = (sent_values.size() != 0) ?
                   sent_values[$urandom_range(0, sent_values.size() - 1)] : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_op(logic cmd, logic [DATA_W-1:0] v);
        set_op_t op;
        op.cmd = cmd;
        op.val = v;
        ops_to_send.insert(ops_to_send.size(), op);
        if (cmd == CMD_ADD)
            sent_values.insert(sent_values.size(), v);
        items_queued++;
    endtask

    // one apb transfer, setup then access
    task automatic cfg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_capacity();
        logic [PDATA_W-1:0] rd;
        cfg_access(1'b0, CAP_ADDR, '0, rd);
        compare_field("capacity readback", PDATA_W'(cap_reg), rd);
    endtask

    // upper data bits are junk, only the low bits land in the register
    task automatic set_capacity(int unsigned cap);
        logic [PDATA_W-1:0] wd;
        logic [PDATA_W-1:0] rd;
        wd            = $urandom;
        wd[CAP_W-1:0] = CAP_W'(cap);
        cfg_access(1'b1, CAP_ADDR, wd, rd);
        cap_reg = cap & ((1 << CAP_W) - 1);
        check_capacity();
    endtask

    task automatic wait_drained();
        while (reports_seen != items_queued)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // input beat driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (ops_to_send.size() != 0)
            begin
                set_op_t op;
                op = ops_to_send.pop_front();
                in_valid <= 1'b1;
                command  <= op.cmd;
                value    <= op.val;
                if ($urandom_range(0, 31) == 0)
                    in_steady = !in_steady;
                in_gap = in_steady ? 0 : $urandom_range(0, 7);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back pressure
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if ($urandom_range(0, 31) == 0)
                out_steady = !out_steady;
            out_stall = out_steady ? 0 : $urandom_range(0, 7);
        end
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor: predict on input beats, check result beats
    always @(posedge clk)
    begin
        span_report_t exp_r;
        in_taken  = rst_n && in_valid && in_ready;
        out_taken = rst_n && out_valid && out_ready;
        if (in_taken)
            expected_reports.insert(expected_reports.size(),
                                    insert_and_report(command, value));
        if (out_taken)
        begin
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected result beat, count %0d", $time, count);
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                compare_field("status", DATA_W'(exp_r.status), DATA_W'(status));
                compare_field("count", DATA_W'(exp_r.count), DATA_W'(count));
                compare_field("spans_valid", DATA_W'(exp_r.spans_valid),
                              DATA_W'(spans_valid));
                compare_field("shortest_span", exp_r.shortest, shortest_span);
                compare_field("longest_span", exp_r.longest, longest_span);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned        cap_plan [15];
        int                 ph;
        int                 n;
        logic [PDATA_W-1:0] rd;

        cap_plan = '{9, 3, 14, 22, 0, 30, 38, 45, 52, 58, 64, 20, 100, 127, 64};
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        held_n       = 0;
        min_gap      = '1;
        cap_reg      = 0;
        cluster_base = $urandom;
        rst_n        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // capacity at reset is zero, so adds bounce
        check_capacity();
        queue_op(CMD_ADD, 32'd5);
        queue_op(CMD_QUERY, 32'h0000_0000);
        wait_drained();

        // extremes, duplicates and a full set
        set_capacity(4);
        queue_op(CMD_ADD, 32'h8000_0000);
        queue_op(CMD_QUERY, 32'hffff_ffff);
        queue_op(CMD_ADD, 32'h7fff_ffff);
        queue_op(CMD_ADD, 32'h0000_0000);
        queue_op(CMD_ADD, 32'h0000_0000);
        queue_op(CMD_ADD, 32'hffff_ffff);
        queue_op(CMD_QUERY, 32'h1234_5678);
        wait_drained();

        // capacity lowered below the count keeps the held values
        set_capacity(2);
        queue_op(CMD_ADD, 32'd3);
        queue_op(CMD_QUERY, 32'd0);
        wait_drained();

        // write to an unmapped register leaves capacity alone
        cfg_access(1'b1, UNMAPPED_ADDR, 32'hffff_ffff, rd);
        check_capacity();
        queue_op(CMD_ADD, 32'd9);
        wait_drained();

        set_capacity(6);
        queue_op(CMD_ADD, 32'hffff_ffff);
        queue_op(CMD_ADD, 32'h0000_0001);
        queue_op(CMD_QUERY, 32'h0000_0000);
        wait_drained();

        // random phases, capacity varied from 0 up to beyond the chain length
        for (ph = 0; ph < 15; ph++)
        begin
            set_capacity(cap_plan[ph]);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                    queue_op(CMD_ADD, pick_value());
                else
                    queue_op(CMD_QUERY, $urandom);
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sorted_set_span_tracker_core.f
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sst_ctrl.sv
rtl/sorted_set_span_tracker_core.sv
dv/testbench.sv
